// ----- rtl/core/closed_tour_length_unit_assert.svh -----
// Assertion macros for the tour length unit; clocked on clk, off during rst.
`ifndef CLOSED_TOUR_LENGTH_UNIT_ASSERT_SVH
`define CLOSED_TOUR_LENGTH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CTLU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CTLU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ctlu_pkg.sv -----
`default_nettype none
package ctlu_pkg;

  localparam int COORD_BITS = 24;
  localparam int SUM_BITS   = 40;

  // |a - b| of two signed coordinates needs one more bit
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int RAD_W  = SQ_W;
  localparam int ROOT_W = DIFF_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int ACC_W  = (SUM_BITS > ROOT_W ? SUM_BITS : ROOT_W) + 1;
  localparam int CNT_W  = $clog2(ROOT_W);

  typedef struct packed {
    logic load_city;
    logic begin_tour;
    logic leg_close;
    logic take_diff;
    logic square_x;
    logic square_y;
    logic root_init;
    logic root_step;
    logic accumulate;
    logic emit;
  } ctlu_cmd_t;

  typedef struct packed {
    logic started;
    logic last;
    logic result_busy;
  } ctlu_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/ctlu_ctrl.sv -----
`default_nettype none
module ctlu_ctrl
  import ctlu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         city_valid,
  output logic         city_ready,
  input  ctlu_status_t status,
  output ctlu_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIFF, S_SQX, S_SQY, S_SUM, S_ROOT, S_ACC, S_EMIT
  } state_t;

  state_t           state;
  logic             ready;
  logic             leg_close;
  logic [CNT_W-1:0] cnt;

  assign city_ready = ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ready     <= 1'b1;
      leg_close <= 1'b0;
      cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (city_valid && ready) begin
            state <= S_CHECK;
            ready <= 1'b0;
          end
        end
        S_CHECK: begin
          if (!status.started) begin
            // first city of a tour: no leg to add
            state <= status.last ? S_EMIT : S_IDLE;
            ready <= !status.last;
          end else begin
            leg_close <= 1'b0;
            state     <= S_DIFF;
          end
        end
        S_DIFF: state <= S_SQX;
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_SUM;
        S_SUM: begin
          cnt   <= CNT_W'(ROOT_W - 1);
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (cnt == '0) begin
            state <= S_ACC;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_ACC: begin
          if (status.last && !leg_close) begin
            // run the closing leg back to the first city
            leg_close <= 1'b1;
            state     <= S_DIFF;
          end else if (status.last) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        S_EMIT: begin
          if (!status.result_busy) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.leg_close = leg_close;
    case (state)
      S_IDLE:  cmd.load_city  = city_valid && ready;
      S_CHECK: cmd.begin_tour = !status.started;
      S_DIFF:  cmd.take_diff  = 1'b1;
      S_SQX:   cmd.square_x   = 1'b1;
      S_SQY:   cmd.square_y   = 1'b1;
      S_SUM:   cmd.root_init  = 1'b1;
      S_ROOT:  cmd.root_step  = 1'b1;
      S_ACC:   cmd.accumulate = 1'b1;
      S_EMIT:  cmd.emit       = !status.result_busy;
      default: cmd.load_city  = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/ctlu_dpath.sv -----
`default_nettype none
module ctlu_dpath
  import ctlu_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  ctlu_cmd_t                    cmd,
  output ctlu_status_t                 status,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  input  logic                         last_city,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic        [SUM_BITS-1:0]   tour_length,
  output logic                         length_saturated
);

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  logic [COORD_BITS-1:0] cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  logic                  last, started, saturated_flag;
  logic [SUM_BITS-1:0]   running_total;

  logic [DIFF_W-1:0]     dx, dy;
  logic [SQ_W-1:0]       sq_x, sq_y;
  logic [RAD_W-1:0]      rad;
  logic [REM_W-1:0]      rem;
  logic [ROOT_W-1:0]     root;

  // leg operands
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [DIFF_W-1:0]     diff_x, diff_y, mag_x, mag_y;
  logic [DIFF_W-1:0]     mul_in;
  logic [SQ_W-1:0]       prod;
  logic [REM_W-1:0]      rem_sh, trial;
  logic                  fits;
  logic [ACC_W-1:0]      acc_sum;

  assign ax = cmd.leg_close ? cur_x   : prev_x;
  assign ay = cmd.leg_close ? cur_y   : prev_y;
  assign bx = cmd.leg_close ? first_x : cur_x;
  assign by = cmd.leg_close ? first_y : cur_y;

  assign diff_x = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
  assign diff_y = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
  assign mag_x  = diff_x[DIFF_W-1] ? (~diff_x + 1'b1) : diff_x;
  assign mag_y  = diff_y[DIFF_W-1] ? (~diff_y + 1'b1) : diff_y;

  // one squarer shared by both axes
  assign mul_in = cmd.square_y ? dy : dx;
  assign prod   = SQ_W'(mul_in) * SQ_W'(mul_in);

  // one radix-2 root digit per step
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  assign acc_sum = ACC_W'(running_total) + ACC_W'(root);

  assign status.started     = started;
  assign status.last        = last;
  assign status.result_busy = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.begin_tour) begin
        started <= 1'b1;
      end else if (cmd.emit) begin
        started <= 1'b0;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_city) begin
      cur_x <= x_coord;
      cur_y <= y_coord;
      last  <= last_city;
    end

    if (cmd.begin_tour) begin
      first_x        <= cur_x;
      first_y        <= cur_y;
      prev_x         <= cur_x;
      prev_y         <= cur_y;
      running_total  <= '0;
      saturated_flag <= 1'b0;
    end

    if (cmd.take_diff) begin
      dx <= mag_x;
      dy <= mag_y;
      // prev is read this cycle for the forward leg, then advance it
      if (!cmd.leg_close) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
    end

    if (cmd.square_x) sq_x <= prod;
    if (cmd.square_y) sq_y <= prod;

    if (cmd.root_init) begin
      rad  <= sq_x + sq_y;
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end

    if (cmd.accumulate) begin
      if (acc_sum > ACC_W'(SUM_MAX)) begin
        running_total  <= SUM_MAX;
        saturated_flag <= 1'b1;
      end else begin
        running_total <= acc_sum[SUM_BITS-1:0];
      end
    end

    if (cmd.emit) begin
      tour_length      <= running_total;
      length_saturated <= saturated_flag;
      running_total    <= '0;
      saturated_flag   <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/closed_tour_length_unit.sv -----
// Channel  Handshake                    Payload
// city     city_valid / city_ready      x_coord, y_coord, last_city
// result   result_valid / result_ready  tour_length, length_saturated
//
// A city that starts a tour adds no leg, and when it is also the last city it
// loads the result register; every other city adds one leg, and a last city
// also adds the closing leg to the first city, then loads the result register.
// Each leg runs a difference, two squarings on one multiplier, a sum, then
// 25 steps of the radix-2 square root unit and one accumulate step.
// Synchronous reset returns to idle with no tour in progress and no result.
// A result waits in its register while the next city is taken; the block
// stalls before overwriting it.
`default_nettype none
module closed_tour_length_unit
  import ctlu_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         city_valid,
  output logic                         city_ready,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  input  logic                         last_city,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic        [SUM_BITS-1:0]   tour_length,
  output logic                         length_saturated
);

  ctlu_cmd_t    cmd;
  ctlu_status_t status;

  ctlu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .city_valid (city_valid),
    .city_ready (city_ready),
    .status     (status),
    .cmd        (cmd)
  );

  ctlu_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .x_coord          (x_coord),
    .y_coord          (y_coord),
    .last_city        (last_city),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .tour_length      (tour_length),
    .length_saturated (length_saturated)
  );

`include "closed_tour_length_unit_assert.svh"

  `CTLU_ASSERT_NXT(a_busy_after_request, city_valid && city_ready, !city_ready,
                   "request not held off")
  `CTLU_ASSERT_IMP(a_no_overwrite, cmd.emit, !result_valid || result_ready,
                   "pending result overwritten")
  `CTLU_ASSERT_NXT(a_emit_shows, cmd.emit, result_valid, "emitted result not shown")
  `CTLU_ASSERT_IMP(a_sat_at_max, result_valid && length_saturated, tour_length == '1,
                   "saturated length not at maximum")

endmodule
`default_nettype wire
